FILE: src/rnlp_pkg.sv
// Shared types and character constants for the radix literal parser.
package rnlp_pkg;

	localparam int unsigned ValueWidth = 16;

	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChDot   = 8'h2E;
	localparam logic [7:0] ChCaret = 8'h5E;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpB   = 8'h42;
	localparam logic [7:0] ChUpD   = 8'h44;
	localparam logic [7:0] ChUpF   = 8'h46;
	localparam logic [7:0] ChUpH   = 8'h48;
	localparam logic [7:0] ChUpO   = 8'h4F;
	localparam logic [7:0] ChUpX   = 8'h58;
	localparam logic [7:0] ChUpZ   = 8'h5A;
	localparam logic [7:0] ChLoA   = 8'h61;
	localparam logic [7:0] ChLoZ   = 8'h7A;
	localparam logic [7:0] CaseGap = 8'h20;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ZERO,
		PH_PLAIN,
		PH_CARET,
		PH_HEX,
		PH_DEC,
		PH_OCT,
		PH_BIN
	} phase_t;

	typedef enum logic [1:0] {
		RDX_2,
		RDX_8,
		RDX_10,
		RDX_16
	} radix_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_PLAIN,
		ACT_RADIX,
		ACT_BADPFX
	} act_t;

	typedef struct packed {
		phase_t                  phase;
		logic [ValueWidth-1:0]   main_accum;
		logic                    main_over;
		logic [ValueWidth-1:0]   dec_accum;
		logic                    dec_over;
		logic                    saw_high_digit;
	} parse_state_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       start_req;
	} char_item_t;

	typedef struct packed {
		logic [ValueWidth-1:0] value;
		logic                  bad_digit;
		logic                  overflow;
		logic                  bad_prefix;
		logic                  took_char;
	} result_item_t;

endpackage

FILE: src/rnlp_if.sv
// Valid/ready stream interfaces for the character and result channels.
interface rnlp_char_if;
	import rnlp_pkg::*;
	logic       valid;
	logic       ready;
	char_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rnlp_result_if;
	import rnlp_pkg::*;
	logic         valid;
	logic         ready;
	result_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/rnlp_mac.sv
// Multiply-by-radix and add-digit accumulator step with overflow detect.
module rnlp_mac
	import rnlp_pkg::*;
(
	input  logic [ValueWidth-1:0] acc,
	input  radix_t                radix,
	input  logic [3:0]            digit,
	output logic [ValueWidth-1:0] sum,
	output logic                  over
);

	localparam int unsigned WideWidth = ValueWidth + 5;

	logic [WideWidth-1:0] acc_w;
	logic [WideWidth-1:0] scaled;
	logic [WideWidth-1:0] total;

	assign acc_w = {5'd0, acc};

	always_comb begin
		case (radix)
			RDX_2:   scaled = acc_w << 1;
			RDX_8:   scaled = acc_w << 3;
			RDX_10:  scaled = (acc_w << 3) + (acc_w << 1);
			RDX_16:  scaled = acc_w << 4;
			default: scaled = acc_w;
		endcase
	end

	assign total = scaled + {{(WideWidth-4){1'b0}}, digit};
	assign sum   = total[ValueWidth-1:0];
	assign over  = |total[WideWidth-1:ValueWidth];

endmodule

FILE: src/rnlp_step.sv
// Next-state and result logic for one character of the literal parser.
module rnlp_step
	import rnlp_pkg::*;
(
	input  parse_state_t state,
	input  char_item_t   item,
	output parse_state_t state_next,
	output logic         res_valid,
	output result_item_t res
);

	logic [7:0]   c;
	logic [7:0]   u;
	logic         is_dig;
	logic         is_let;
	logic         is_hex_let;
	logic [3:0]   dig;
	logic [3:0]   rdx_dig;
	logic         rdx_ok;
	radix_t       rdx;
	act_t         act;
	phase_t       phase_go;
	logic         ends;
	parse_state_t base;
	logic [ValueWidth-1:0] main_sum;
	logic [ValueWidth-1:0] dec_sum;
	logic         main_ovf;
	logic         dec_ovf;
	radix_t       main_rdx;
	logic [3:0]   main_dig;

	assign c          = item.char_code;
	assign u          = (c >= ChLoA && c <= ChLoZ) ? c - CaseGap : c;
	assign is_dig     = c >= ChZero && c <= ChNine;
	assign is_let     = u >= ChUpA && u <= ChUpZ;
	assign is_hex_let = u >= ChUpA && u <= ChUpF;
	assign dig        = c[3:0];
	// Letters A..F sit at codes 1..6 in their low nibble, so adding nine gives 10..15.
	assign rdx_dig    = is_dig ? dig : u[3:0] + 4'd9;

	// A start character discards whatever literal was in progress.
	assign base = item.start_req ? parse_state_t'{phase: PH_IDLE, default: '0} : state;

	always_comb begin
		case (state.phase)
			PH_HEX:  rdx = RDX_16;
			PH_DEC:  rdx = RDX_10;
			PH_OCT:  rdx = RDX_8;
			default: rdx = RDX_2;
		endcase
	end

	always_comb begin
		case (rdx)
			RDX_2:   rdx_ok = is_dig && dig < 4'd2;
			RDX_8:   rdx_ok = is_dig && dig < 4'd8;
			RDX_10:  rdx_ok = is_dig;
			default: rdx_ok = is_dig || is_hex_let;
		endcase
	end

	// Decode what this character does and where the parser goes if the literal goes on.
	always_comb begin
		act      = ACT_NONE;
		phase_go = state.phase;
		if (item.start_req) begin
			if (c == ChZero) begin
				phase_go = PH_ZERO;
			end else if (c == ChCaret) begin
				phase_go = PH_CARET;
			end else begin
				act      = ACT_PLAIN;
				phase_go = PH_PLAIN;
			end
		end else begin
			case (state.phase)
				PH_IDLE: phase_go = PH_IDLE;
				PH_ZERO: begin
					if (u == ChUpX) begin
						phase_go = PH_HEX;
					end else if (u == ChUpD) begin
						phase_go = PH_DEC;
					end else if (u == ChUpB) begin
						phase_go = PH_BIN;
					end else begin
						act      = ACT_PLAIN;
						phase_go = PH_PLAIN;
					end
				end
				PH_PLAIN: act = ACT_PLAIN;
				PH_CARET: begin
					if (u == ChUpX || u == ChUpH) begin
						phase_go = PH_HEX;
					end else if (u == ChUpD) begin
						phase_go = PH_DEC;
					end else if (u == ChUpO) begin
						phase_go = PH_OCT;
					end else if (u == ChUpB) begin
						phase_go = PH_BIN;
					end else begin
						act = ACT_BADPFX;
					end
				end
				default: act = ACT_RADIX;
			endcase
		end
	end

	assign ends = (act == ACT_PLAIN && !is_dig) || (act == ACT_RADIX && !rdx_ok) ||
		(act == ACT_BADPFX);

	assign main_rdx = (act == ACT_PLAIN) ? RDX_8 : rdx;
	assign main_dig = (act == ACT_PLAIN) ? {1'b0, dig[2:0]} : rdx_dig;

	rnlp_mac u_main_mac (
		.acc   (base.main_accum),
		.radix (main_rdx),
		.digit (main_dig),
		.sum   (main_sum),
		.over  (main_ovf)
	);

	rnlp_mac u_dec_mac (
		.acc   (base.dec_accum),
		.radix (RDX_10),
		.digit (dig),
		.sum   (dec_sum),
		.over  (dec_ovf)
	);

	// Phase, accumulators and the result.
	always_comb begin
		state_next.phase          = ends ? PH_IDLE : phase_go;
		state_next.main_accum     = base.main_accum;
		state_next.main_over      = base.main_over;
		state_next.dec_accum      = base.dec_accum;
		state_next.dec_over       = base.dec_over;
		state_next.saw_high_digit = base.saw_high_digit;
		res_valid                 = ends;
		res                       = '0;
		case (act)
			ACT_PLAIN: begin
				if (is_dig) begin
					state_next.main_accum     = main_sum;
					state_next.main_over      = base.main_over | main_ovf;
					state_next.dec_accum      = dec_sum;
					state_next.dec_over       = base.dec_over | dec_ovf;
					state_next.saw_high_digit = base.saw_high_digit | dig[3];
				end else if (c == ChDot) begin
					res.value     = base.dec_accum;
					res.overflow  = base.dec_over;
					res.took_char = 1'b1;
				end else if (base.saw_high_digit) begin
					res.bad_digit = 1'b1;
				end else begin
					res.value    = base.main_accum;
					res.overflow = base.main_over;
				end
			end
			ACT_RADIX: begin
				if (rdx_ok) begin
					state_next.main_accum = main_sum;
					state_next.main_over  = base.main_over | main_ovf;
				end else begin
					res.value     = base.main_accum;
					res.overflow  = base.main_over;
					res.bad_digit = (rdx == RDX_16) ? is_let : is_dig;
				end
			end
			ACT_BADPFX: res.bad_prefix = 1'b1;
			default: ;
		endcase
	end

endmodule

FILE: src/radix_number_literal_parser.sv
// Top level: input register, parse step and result register of the literal parser.
//
// Usage: characters arrive on char_in, one request per character, with
// start_req set on the first character of each numeric literal. A literal
// ends on the first character that cannot continue it, and that character
// produces exactly one request on result_out carrying the value (low 16
// bits) and the bad_digit, overflow, bad_prefix and took_char flags.
// Characters outside a literal, and characters that continue one, produce
// nothing.
// A character accepted on char_in is registered in the input register, parsed
// by the parse step, and its result goes to the result register on result_out.
// Throughput is one character per cycle while result_out is not stalled; the
// limit is the single parse step between the input register and the result
// register. When result_out stalls, the held character waits in the input
// register and char_in drops ready until the result is taken.
// Reset clears the parser to idle, empties both registers, and drops any
// literal in progress.
module radix_number_literal_parser
	import rnlp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	rnlp_char_if.sink     char_in,
	rnlp_result_if.source result_out
);

	char_item_t   char_s1;
	logic         valid_s1;
	parse_state_t state_q;
	parse_state_t state_next;
	logic         step_res_valid;
	result_item_t step_res;
	result_item_t res_q;
	logic         res_valid_q;
	logic         adv;

	assign adv           = valid_s1 && (!res_valid_q || result_out.ready);
	assign char_in.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_in.ready) begin
			valid_s1 <= char_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_in.ready && char_in.valid) begin
			char_s1 <= char_in.data;
		end
	end

	rnlp_step u_step (
		.state      (state_q),
		.item       (char_s1),
		.state_next (state_next),
		.res_valid  (step_res_valid),
		.res        (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, default: '0};
		end else if (adv) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= step_res_valid;
		end else if (result_out.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && step_res_valid) begin
			res_q <= step_res;
		end
	end

	assign result_out.valid = res_valid_q;
	assign result_out.data  = res_q;

	// Every result returns the parser to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && step_res_valid |=> state_q.phase == PH_IDLE)
		else $error("parser not idle after a result");

	// A stalled result is neither lost nor overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !result_out.ready |=> res_valid_q && $stable(res_q))
		else $error("stalled result changed");

	// Parser state only moves when a character is consumed.
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(state_q))
		else $error("state changed without a character");

	// An empty input register always takes a character.
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> char_in.ready)
		else $error("input blocked while empty");

endmodule

FILE: tb/radix_number_literal_parser_tb.sv
// Self-checking testbench for the radix literal parser: directed and random character streams.
module radix_number_literal_parser_tb;
	import rnlp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CharTarget = 1500;
	localparam int unsigned StallLimit = 1000;

	// Tracks the parse of each literal and holds the results still owed by the block.
	class literal_scoreboard;
		phase_t                ph;
		logic [ValueWidth-1:0] main_val;
		bit                    main_ovf;
		logic [ValueWidth-1:0] dec_val;
		bit                    dec_ovf;
		bit                    high_seen;
		result_item_t          pending[$];
		int unsigned           errors;
		int unsigned           chars_used;
		int unsigned           results_seen;
		int unsigned           n_ovf;
		int unsigned           n_bad_digit;
		int unsigned           n_bad_prefix;
		int unsigned           n_took;

		function new();
			ph = PH_IDLE;
			clear_parse();
		endfunction

		function void clear_parse();
			main_val = '0;
			main_ovf = 1'b0;
			dec_val = '0;
			dec_ovf = 1'b0;
			high_seen = 1'b0;
		endfunction

		function logic [7:0] upcase(logic [7:0] c);
			return (c >= ChLoA && c <= ChLoZ) ? c - CaseGap : c;
		endfunction

		function bit is_digit(logic [7:0] c);
			return c >= ChZero && c <= ChNine;
		endfunction

		function bit is_letter(logic [7:0] c);
			logic [7:0] u;
			u = upcase(c);
			return u >= ChUpA && u <= ChUpZ;
		endfunction

		function logic [ValueWidth-1:0] mac(logic [ValueWidth-1:0] acc, int unsigned radix,
				int unsigned d, inout bit ovf);
			int unsigned t;
			t = int'(acc) * radix + d;
			if (t > 32'h0000_FFFF) begin
				ovf = 1'b1;
			end
			return t[ValueWidth-1:0];
		endfunction

		function void emit(logic [ValueWidth-1:0] v, bit bad, bit ovf, bit bp, bit took);
			result_item_t r;
			r.value = v;
			r.bad_digit = bad;
			r.overflow = ovf;
			r.bad_prefix = bp;
			r.took_char = took;
			pending.insert(pending.size(), r);
			ph = PH_IDLE;
		endfunction

		// Unprefixed digits build the octal and decimal readings side by side.
		function void plain_step(logic [7:0] c);
			int unsigned d;
			if (is_digit(c)) begin
				d = c - ChZero;
				main_val = mac(main_val, 8, d & 7, main_ovf);
				dec_val = mac(dec_val, 10, d, dec_ovf);
				if (d >= 8) begin
					high_seen = 1'b1;
				end
			end else if (c == ChDot) begin
				emit(dec_val, 1'b0, dec_ovf, 1'b0, 1'b1);
			end else if (high_seen) begin
				emit('0, 1'b1, 1'b0, 1'b0, 1'b0);
			end else begin
				emit(main_val, 1'b0, main_ovf, 1'b0, 1'b0);
			end
		endfunction

		function void radix_step(int unsigned radix, logic [7:0] c);
			logic [7:0]  u;
			int unsigned d;
			bit          bad;
			u = upcase(c);
			d = 99;
			if (is_digit(c)) begin
				d = c - ChZero;
			end else if (radix == 16 && u >= ChUpA && u <= ChUpF) begin
				d = 10 + (u - ChUpA);
			end
			if (d < radix) begin
				main_val = mac(main_val, radix, d, main_ovf);
			end else begin
				bad = (radix == 16) ? is_letter(c) : is_digit(c);
				emit(main_val, bad, main_ovf, 1'b0, 1'b0);
			end
		endfunction

		function void note_char(char_item_t it);
			logic [7:0] c;
			logic [7:0] u;
			c = it.char_code;
			u = upcase(c);
			if (it.start_req) begin
				chars_used++;
				clear_parse();
				if (c == ChZero) begin
					ph = PH_ZERO;
				end else if (c == ChCaret) begin
					ph = PH_CARET;
				end else begin
					ph = PH_PLAIN;
					plain_step(c);
				end
				return;
			end
			// Characters between literals are dropped by the block.
			if (ph == PH_IDLE) begin
				return;
			end
			chars_used++;
			case (ph)
				PH_ZERO: begin
					if (u == ChUpX) begin
						ph = PH_HEX;
					end else if (u == ChUpD) begin
						ph = PH_DEC;
					end else if (u == ChUpB) begin
						ph = PH_BIN;
					end else begin
						ph = PH_PLAIN;
						plain_step(c);
					end
				end
				PH_PLAIN: plain_step(c);
				PH_CARET: begin
					if (u == ChUpX || u == ChUpH) begin
						ph = PH_HEX;
					end else if (u == ChUpD) begin
						ph = PH_DEC;
					end else if (u == ChUpO) begin
						ph = PH_OCT;
					end else if (u == ChUpB) begin
						ph = PH_BIN;
					end else begin
						emit('0, 1'b0, 1'b0, 1'b1, 1'b0);
					end
				end
				PH_HEX: radix_step(16, c);
				PH_DEC: radix_step(10, c);
				PH_OCT: radix_step(8, c);
				PH_BIN: radix_step(2, c);
				default: ;
			endcase
		endfunction

		function void compare(string fname, logic [ValueWidth-1:0] exp_v,
				logic [ValueWidth-1:0] got_v);
			if (exp_v !== got_v) begin
				$display("%0t: %s mismatch, expected %h, got %h", $time, fname, exp_v, got_v);
				errors++;
			end
		endfunction

		function void check_result(result_item_t got);
			result_item_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, got value %h flags %b%b%b%b",
					$time, got.value, got.bad_digit, got.overflow, got.bad_prefix,
					got.took_char);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			results_seen++;
			n_ovf += exp_r.overflow;
			n_bad_digit += exp_r.bad_digit;
			n_bad_prefix += exp_r.bad_prefix;
			n_took += exp_r.took_char;
			compare("value", exp_r.value, got.value);
			compare("bad_digit", exp_r.bad_digit, got.bad_digit);
			compare("overflow", exp_r.overflow, got.overflow);
			compare("bad_prefix", exp_r.bad_prefix, got.bad_prefix);
			compare("took_char", exp_r.took_char, got.took_char);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   quiet;
	int unsigned idle_cycles = 0;

	rnlp_char_if   char_bus();
	rnlp_result_if result_bus();

	literal_scoreboard sb;

	radix_number_literal_parser u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_in    (char_bus),
		.result_out (result_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one; none at all in quiet stretches.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) begin
			return 0;
		end
		if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] rcase(logic [7:0] letter);
		return $urandom_range(0, 1) ? letter + CaseGap : letter;
	endfunction

	function automatic logic [7:0] digit_char(int unsigned radix);
		int unsigned v;
		v = $urandom_range(0, radix - 1);
		if (v < 10) begin
			return ChZero + v;
		end
		return rcase(ChUpA + v - 10);
	endfunction

	function automatic logic [7:0] pick_end();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			return $urandom_range(0, 255);
		end
		if (r < 55) begin
			return $urandom_range(8'h20, 8'h2F);
		end
		if (r < 75) begin
			return rcase(ChUpA + $urandom_range(0, 25));
		end
		if (r < 90) begin
			return ChZero + $urandom_range(0, 9);
		end
		return ChDot;
	endfunction

	task automatic send_char(logic [7:0] c, logic s);
		int unsigned gap;
		char_item_t  it;
		gap = pick_gap();
		it.char_code = c;
		it.start_req = s;
		if (gap > 0) begin
			char_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_bus.valid <= 1'b1;
		char_bus.data <= it;
		do begin
			@(posedge clk);
		end while (!char_bus.ready);
		sb.note_char(it);
	endtask

	task automatic send_text(string s, bit first_start);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i], first_start && i == 0);
		end
	endtask

	task automatic random_literal();
		logic [7:0]  body[$];
		int unsigned kind;
		int unsigned radix;
		int unsigned ndig;
		int unsigned noise;
		kind = $urandom_range(0, 19);
		radix = 8;
		ndig = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 5) : $urandom_range(1, 20);
		if (kind == 0) begin
			// Fully random request, start flag included.
			send_char($urandom_range(0, 255), $urandom_range(0, 1));
			return;
		end
		if (kind < 7) begin
			for (int i = 0; i < ndig; i++) begin
				body.insert(body.size(), ($urandom_range(0, 99) < 12)
					? ChZero + $urandom_range(8, 9) : ChZero + $urandom_range(0, 7));
			end
			if ($urandom_range(0, 99) < 30) begin
				body.insert(body.size(), ChDot);
			end
		end else if (kind < 17) begin
			if (kind < 11) begin
				body.insert(body.size(), ChZero);
				case ($urandom_range(0, 2))
					0: begin body.insert(body.size(), rcase(ChUpX)); radix = 16; end
					1: begin body.insert(body.size(), rcase(ChUpD)); radix = 10; end
					default: begin body.insert(body.size(), rcase(ChUpB)); radix = 2; end
				endcase
			end else begin
				body.insert(body.size(), ChCaret);
				case ($urandom_range(0, 4))
					0: begin body.insert(body.size(), rcase(ChUpX)); radix = 16; end
					1: begin body.insert(body.size(), rcase(ChUpH)); radix = 16; end
					2: begin body.insert(body.size(), rcase(ChUpD)); radix = 10; end
					3: begin body.insert(body.size(), rcase(ChUpO)); radix = 8; end
					default: begin body.insert(body.size(), rcase(ChUpB)); radix = 2; end
				endcase
			end
			for (int i = 0; i < ndig; i++) begin
				body.insert(body.size(), digit_char(radix));
			end
		end else if (kind < 19) begin
			body.insert(body.size(), ChCaret);
			body.insert(body.size(), rcase(ChUpA + $urandom_range(0, 25)));
		end else begin
			body.insert(body.size(), ChZero);
		end
		// Most literals get an ending character; the rest are cut off by the next start.
		if ($urandom_range(0, 99) < 90) begin
			body.insert(body.size(), pick_end());
		end
		foreach (body[i]) begin
			send_char(body[i], i == 0);
		end
		if ($urandom_range(0, 99) < 20) begin
			noise = $urandom_range(1, 3);
			repeat (noise) send_char($urandom_range(0, 255), 1'b0);
		end
	endtask

	// Result side: random back-pressure and the check of every accepted request.
	initial begin
		int unsigned stall;
		stall = 0;
		result_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_bus.valid && result_bus.ready) begin
				sb.check_result(result_bus.data);
			end
			if (stall > 0) begin
				result_bus.ready <= 1'b0;
				stall--;
			end else begin
				result_bus.ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if ((char_bus.valid && char_bus.ready) || (result_bus.valid && result_bus.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= StallLimit) begin
			$display("%0t: no request moved for %0d cycles", $time, idle_cycles);
			$display("radix_number_literal_parser_tb: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int unsigned literals;
		sb = new();
		quiet = 1'b0;
		char_bus.valid = 1'b0;
		char_bus.data = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("Q", 1'b0);
		send_text("0xFfZ", 1'b1);
		send_text("^o78", 1'b1);
		send_text("19.", 1'b1);
		send_text("9 ", 1'b1);
		send_text(".", 1'b1);
		send_text("^R", 1'b1);
		send_text("7", 1'b1);
		send_text("777777+", 1'b1);

		literals = 0;
		while (sb.chars_used < CharTarget) begin
			if (literals % 40 == 0) begin
				quiet = ($urandom_range(0, 3) == 0);
			end
			random_literal();
			literals++;
		end
		char_bus.valid <= 1'b0;

		while (sb.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);

		$display("Sent %0d parsed characters in %0d random literals; checked %0d results.",
			sb.chars_used, literals, sb.results_seen);
		$display("Results with overflow %0d, bad digit %0d, bad prefix %0d, decimal point %0d.",
			sb.n_ovf, sb.n_bad_digit, sb.n_bad_prefix, sb.n_took);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("radix_number_literal_parser_tb: clean");
		end else begin
			$display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending.size());
			$display("radix_number_literal_parser_tb: errors");
		end
		$finish;
	end

endmodule
